// ----- rtl/lmfe_pkg.sv -----
// Shared types, codes and helper functions of the LIN master frame engine.
`timescale 1ns / 1ps
`default_nettype none

package lmfe_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RECV  = 2'd2;

    // Symbol kinds of a result transaction
    localparam logic [2:0] KIND_BREAK    = 3'd0;
    localparam logic [2:0] KIND_SYNC     = 3'd1;
    localparam logic [2:0] KIND_PID      = 3'd2;
    localparam logic [2:0] KIND_DATA     = 3'd3;
    localparam logic [2:0] KIND_CHECKSUM = 3'd4;
    localparam logic [2:0] KIND_STATUS   = 3'd5;

    // Bit positions in the pending-symbol mask, in emission order
    localparam int PB_BREAK    = 0;
    localparam int PB_SYNC     = 1;
    localparam int PB_PID      = 2;
    localparam int PB_DATA     = 3;
    localparam int PB_CHECKSUM = 4;
    localparam int PB_STATUS   = 5;
    localparam int PEND_W      = 6;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [5:0] ID_MASK   = 6'h3F;
    localparam logic [4:0] BRK_MIN   = 5'd13;
    localparam logic [4:0] BRK_RESET = 5'd13;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified frame step, handed from the front to the back
    typedef struct packed {
        logic [PEND_W-1:0] pend;
        logic [4:0]        brk;
        logic [7:0]        pid;
        logic [7:0]        data;
        logic [7:0]        cks;
        logic              ok;
    } t_desc;

    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id & ID_MASK};
    endfunction

    // 8-bit add with end-around carry
    function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lmfe_if.sv -----
// Valid/ready channel interfaces for the frame engine input and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface lmfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] frame_id;
    logic       classic;
    logic [7:0] data_byte;
    logic       first;
    logic       last;

    modport source (
        output valid, operation, frame_id, classic, data_byte, first, last,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_id, classic, data_byte, first, last,
        output ready
    );
endinterface

interface lmfe_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] symbol_kind;
    logic [7:0] symbol_value;
    logic       checksum_ok;
    logic       last_of_run;

    modport source (
        output valid, symbol_kind, symbol_value, checksum_ok, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, symbol_kind, symbol_value, checksum_ok, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/lmfe_front.sv -----
// Front end: accepts input transactions, tracks the checksum and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module lmfe_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [4:0]      i_cfg_wdata,
    lmfe_in_if.sink              i_in,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output lmfe_pkg::t_desc      o_desc
);

    logic [4:0] r_brk;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       accept;
    logic [7:0] hdr_pid;
    logic [7:0] hdr_base;
    logic [7:0] wr_base;
    logic [7:0] wr_sum;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    assign hdr_pid  = lmfe_pkg::make_pid(i_in.frame_id);
    assign hdr_base = i_in.classic ? 8'd0 : hdr_pid;
    assign wr_base  = i_in.first ? hdr_base : r_sum;
    assign wr_sum   = lmfe_pkg::fold_add(wr_base, i_in.data_byte);

    always_comb begin
        n_sum       = r_sum;
        o_desc.pend = '0;
        o_desc.brk  = (r_brk < lmfe_pkg::BRK_MIN) ? lmfe_pkg::BRK_MIN : r_brk;
        o_desc.pid  = hdr_pid;
        o_desc.data = i_in.data_byte;
        o_desc.cks  = ~wr_sum;
        o_desc.ok   = (i_in.data_byte == ~r_sum);
        case (i_in.operation)
            lmfe_pkg::OP_WRITE: begin
                n_sum = wr_sum;
                o_desc.pend[lmfe_pkg::PB_BREAK]    = i_in.first;
                o_desc.pend[lmfe_pkg::PB_SYNC]     = i_in.first;
                o_desc.pend[lmfe_pkg::PB_PID]      = i_in.first;
                o_desc.pend[lmfe_pkg::PB_DATA]     = 1'b1;
                o_desc.pend[lmfe_pkg::PB_CHECKSUM] = i_in.last;
            end
            lmfe_pkg::OP_READ: begin
                n_sum = hdr_base;
                o_desc.pend[lmfe_pkg::PB_BREAK] = 1'b1;
                o_desc.pend[lmfe_pkg::PB_SYNC]  = 1'b1;
                o_desc.pend[lmfe_pkg::PB_PID]   = 1'b1;
            end
            lmfe_pkg::OP_RECV: begin
                // checksum byte reports status, any other byte only accumulates
                if (i_in.last) begin
                    o_desc.pend[lmfe_pkg::PB_STATUS] = 1'b1;
                end else begin
                    n_sum = lmfe_pkg::fold_add(r_sum, i_in.data_byte);
                end
            end
            default: begin
                n_sum = r_sum;
            end
        endcase
    end

    // items that yield no symbol are consumed here and never queued
    assign o_push = accept && (o_desc.pend != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk <= lmfe_pkg::BRK_RESET;
            r_sum <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_brk <= i_cfg_wdata;
            end
            if (accept) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lmfe_queue.sv -----
// Two-entry queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module lmfe_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  lmfe_pkg::t_desc      i_desc,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output lmfe_pkg::t_desc      o_head
);

    lmfe_pkg::t_desc r_mem [lmfe_pkg::QUEUE_DEPTH];
    logic [lmfe_pkg::QPTR_W-1:0] r_wp;
    logic [lmfe_pkg::QPTR_W-1:0] r_rp;
    logic [lmfe_pkg::QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == lmfe_pkg::QCNT_W'(lmfe_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lmfe_back.sv -----
// Back end: expands each queued item into its symbols, one result transaction per cycle unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module lmfe_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  lmfe_pkg::t_desc      i_q_head,
    output logic                 o_pop,
    lmfe_out_if.source           o_out
);

    lmfe_pkg::t_desc r_cur;
    lmfe_pkg::t_desc n_cur;
    logic            r_busy;
    logic            r_ovalid;
    logic [2:0]      r_kind;
    logic [7:0]      r_value;
    logic            r_ok;
    logic            r_last;

    lmfe_pkg::t_desc               cur;
    logic                          cur_valid;
    logic                          slot_free;
    logic                          fire;
    logic [lmfe_pkg::PEND_W-1:0]   low;
    logic [lmfe_pkg::PEND_W-1:0]   rem;
    logic [2:0]                    s_kind;
    logic [7:0]                    s_value;
    logic                          s_ok;

    assign cur       = r_busy ? r_cur : i_q_head;
    assign cur_valid = r_busy || !i_q_empty;
    assign slot_free = !r_ovalid || o_out.ready;
    assign fire      = cur_valid && slot_free;
    assign o_pop     = fire && !r_busy;

    // lowest pending bit is the next symbol on the bus
    assign low = cur.pend & (~cur.pend + 1'b1);
    assign rem = cur.pend & ~low;

    always_comb begin
        n_cur      = cur;
        n_cur.pend = rem;
    end

    always_comb begin
        s_ok = 1'b0;
        if (cur.pend[lmfe_pkg::PB_BREAK]) begin
            s_kind  = lmfe_pkg::KIND_BREAK;
            s_value = {3'd0, cur.brk};
        end else if (cur.pend[lmfe_pkg::PB_SYNC]) begin
            s_kind  = lmfe_pkg::KIND_SYNC;
            s_value = lmfe_pkg::SYNC_BYTE;
        end else if (cur.pend[lmfe_pkg::PB_PID]) begin
            s_kind  = lmfe_pkg::KIND_PID;
            s_value = cur.pid;
        end else if (cur.pend[lmfe_pkg::PB_DATA]) begin
            s_kind  = lmfe_pkg::KIND_DATA;
            s_value = cur.data;
        end else if (cur.pend[lmfe_pkg::PB_CHECKSUM]) begin
            s_kind  = lmfe_pkg::KIND_CHECKSUM;
            s_value = cur.cks;
        end else begin
            s_kind  = lmfe_pkg::KIND_STATUS;
            s_value = cur.data;
            s_ok    = cur.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur <= n_cur;
        end
        if (slot_free && cur_valid) begin
            r_kind  <= s_kind;
            r_value <= s_value;
            r_ok    <= s_ok;
            r_last  <= (rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (fire) begin
                r_busy <= (rem != '0);
            end
            if (slot_free) begin
                r_ovalid <= cur_valid;
            end
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.symbol_kind  = r_kind;
    assign o_out.symbol_value = r_value;
    assign o_out.checksum_ok  = r_ok;
    assign o_out.last_of_run  = r_last;

endmodule

`default_nettype wire

// ----- rtl/lin_master_frame_engine.sv -----
// Top level of the LIN master frame engine: front end, item queue and symbol back end.
`timescale 1ns / 1ps
`default_nettype none

// LIN master frame engine. Each input transaction is a write byte, a read
// request or a received response byte; the engine answers with the bus
// symbols it implies (break, sync, protected id, data, checksum) or a read
// status carrying the checksum verdict, with last_of_run on the final symbol
// of each input. The front end accepts one input per cycle while the
// two-entry item queue has room, and updates the running checksum at once;
// received bytes that are not the checksum byte produce no output. The back
// end emits one symbol per cycle into an output register unless the output
// stalls; an input yields up to five symbols for a first write byte,
// three for a read request, one or two otherwise. The break length register
// may be written at any time via i_cfg_we; values below 13 are reported as 13.
module lin_master_frame_engine (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    lmfe_in_if.sink         i_in,
    lmfe_out_if.source      o_out
);

    lmfe_pkg::t_desc push_desc;
    lmfe_pkg::t_desc head_desc;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    lmfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    lmfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_desc)
    );

    lmfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (head_desc),
        .o_pop     (pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    // a break transaction is always followed straight away by the sync byte
    a_sync_after_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.symbol_kind == lmfe_pkg::KIND_BREAK)
        |=> (o_out.valid && o_out.symbol_kind == lmfe_pkg::KIND_SYNC))
        else $error("sync symbol did not follow break");

    a_break_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.symbol_kind == lmfe_pkg::KIND_BREAK)
        |-> (o_out.symbol_value >= 8'd13 && o_out.symbol_value <= 8'd31
             && !o_out.last_of_run))
        else $error("break symbol out of range or ends a run");

    a_ok_only_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.symbol_kind != lmfe_pkg::KIND_STATUS)
        |-> !o_out.checksum_ok)
        else $error("checksum_ok set on a non-status symbol");
`endif

endmodule

`default_nettype wire
